@@ hw/rtl/wlcf_pkg.sv @@
`timescale 1ns / 1ps

package wlcf_pkg;

  localparam int MAX_SIDE_DEF   = 256;
  localparam int MAX_RADIUS_DEF = 31;
  localparam int ELEV_BITS_DEF  = 16;

  localparam int COORD_W  = 8;
  localparam int HEIGHT_W = 16;
  localparam int CNT_W    = 12;
  localparam int FRAC_W   = 16;
  localparam int SIDE_W   = 9;
  localparam int RAD_W    = 5;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS      = 2'd2;

  localparam logic [SIDE_W-1:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [SIDE_W-1:0] GRID_HEIGHT_RST = 9'd256;
  localparam logic [RAD_W-1:0]  RADIUS_RST      = 5'd5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [SIDE_W-1:0] grid_width;
    logic [SIDE_W-1:0] grid_height;
    logic [RAD_W-1:0]  radius_cells;
  } cfg_t;

endpackage

@@ hw/rtl/wlcf_in_if.sv @@
`timescale 1ns / 1ps

interface wlcf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [wlcf_pkg::COORD_W-1:0]  col;
  logic [wlcf_pkg::COORD_W-1:0]  row;
  logic [wlcf_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, cmd, col, row, height, input ready);
  modport sink (input valid, cmd, col, row, height, output ready);
endinterface

@@ hw/rtl/wlcf_out_if.sv @@
`timescale 1ns / 1ps

interface wlcf_out_if;
  logic                        valid;
  logic                        ready;
  logic [wlcf_pkg::CNT_W-1:0]  lower_count;
  logic [wlcf_pkg::CNT_W-1:0]  window_count;
  logic [wlcf_pkg::FRAC_W-1:0] lower_fraction;
  logic                        query_error;

  modport source (output valid, lower_count, window_count, lower_fraction, query_error,
                  input ready);
  modport sink (input valid, lower_count, window_count, lower_fraction, query_error,
                output ready);
endinterface

@@ hw/rtl/wlcf_cfg.sv @@
`timescale 1ns / 1ps

module wlcf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wlcf_pkg::APB_AW-1:0] paddr,
  input  logic [wlcf_pkg::APB_DW-1:0] pwdata,
  output logic [wlcf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output wlcf_pkg::cfg_t              cfg
);

  wlcf_pkg::cfg_t cfg_r;
  wlcf_pkg::cfg_t cfg_nxt;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[wlcf_pkg::APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        wlcf_pkg::REG_GRID_WIDTH:  cfg_nxt.grid_width   = pwdata[wlcf_pkg::SIDE_W-1:0];
        wlcf_pkg::REG_GRID_HEIGHT: cfg_nxt.grid_height  = pwdata[wlcf_pkg::SIDE_W-1:0];
        wlcf_pkg::REG_RADIUS:      cfg_nxt.radius_cells = pwdata[wlcf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wlcf_pkg::REG_GRID_WIDTH:  prdata = wlcf_pkg::APB_DW'(cfg_r.grid_width);
      wlcf_pkg::REG_GRID_HEIGHT: prdata = wlcf_pkg::APB_DW'(cfg_r.grid_height);
      wlcf_pkg::REG_RADIUS:      prdata = wlcf_pkg::APB_DW'(cfg_r.radius_cells);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width   <= wlcf_pkg::GRID_WIDTH_RST;
      cfg_r.grid_height  <= wlcf_pkg::GRID_HEIGHT_RST;
      cfg_r.radius_cells <= wlcf_pkg::RADIUS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/wlcf_store.sv @@
`timescale 1ns / 1ps

module wlcf_store #(
  parameter int ADDR_W    = 16,
  parameter int ELEV_BITS = wlcf_pkg::ELEV_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [ELEV_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [ELEV_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [ELEV_BITS-1:0] mem [DEPTH];
  logic [ELEV_BITS-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/wlcf_div.sv @@
`timescale 1ns / 1ps

module wlcf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wlcf_pkg::CNT_W-1:0]  num,
  input  logic [wlcf_pkg::CNT_W-1:0]  den,
  output logic                        done,
  output logic [wlcf_pkg::FRAC_W-1:0] quot
);

  localparam int STEP_W = $clog2(wlcf_pkg::FRAC_W + 1);

  logic                        busy_r;
  logic [STEP_W-1:0]           cnt_r;
  logic [wlcf_pkg::CNT_W-1:0]  rem_r;
  logic [wlcf_pkg::CNT_W-1:0]  den_r;
  logic [wlcf_pkg::FRAC_W-1:0] quot_r;
  logic [wlcf_pkg::CNT_W:0]    rem2;
  logic                        ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};
  assign done = busy_r && (cnt_r == STEP_W'(1));
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(wlcf_pkg::FRAC_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? wlcf_pkg::CNT_W'(rem2 - {1'b0, den_r}) : rem2[wlcf_pkg::CNT_W-1:0];
      quot_r <= {quot_r[wlcf_pkg::FRAC_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/wlcf_scan.sv @@
`timescale 1ns / 1ps

module wlcf_scan #(
  parameter int MAX_SIDE   = wlcf_pkg::MAX_SIDE_DEF,
  parameter int MAX_RADIUS = wlcf_pkg::MAX_RADIUS_DEF,
  parameter int ELEV_BITS  = wlcf_pkg::ELEV_BITS_DEF,
  parameter int SW         = $clog2(MAX_SIDE)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wlcf_pkg::cfg_t              cfg,
  wlcf_in_if.sink                     in_ch,
  wlcf_out_if.source                  out_ch,
  output logic                        mem_we,
  output logic [2*SW-1:0]             mem_waddr,
  output logic [ELEV_BITS-1:0]        mem_wdata,
  output logic                        mem_re,
  output logic [2*SW-1:0]             mem_raddr,
  input  logic [ELEV_BITS-1:0]        mem_rdata,
  output logic                        div_start,
  input  logic                        div_done,
  output logic [wlcf_pkg::CNT_W-1:0]  div_num,
  output logic [wlcf_pkg::CNT_W-1:0]  div_den,
  input  logic [wlcf_pkg::FRAC_W-1:0] div_quot
);

  localparam int CW = wlcf_pkg::SIDE_W;
  localparam int NW = wlcf_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CTR   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_DIVGO = 7'b0010000,
    S_DIVW  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             col_r, row_r, c0_r, c1_r, r1_r, ci_r, ri_r;
  logic [CW-1:0]             col_nxt, row_nxt, c0_nxt, c1_nxt, r1_nxt, ci_nxt, ri_nxt;
  logic [ELEV_BITS-1:0]      center_r;
  logic                      ctr_pend_r, cmp_pend_r;
  logic [NW-1:0]             lower_r, total_r, lower_nxt, total_nxt;
  logic                      err_r, err_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [NW-1:0]             out_lower_r, out_total_r;
  logic [wlcf_pkg::FRAC_W-1:0] out_frac_r;
  logic                      out_err_r;
  logic                      load;

  logic [CW-1:0]             w, gh;
  logic [wlcf_pkg::RAD_W-1:0] r;
  logic [CW-1:0]             ic, ir, rr, col_hi, row_hi;
  logic                      in_grid, accept;

  always_comb begin
    if (cfg.grid_width == '0) begin
      w = CW'(1);
    end else if (32'(cfg.grid_width) > MAX_SIDE) begin
      w = CW'(MAX_SIDE);
    end else begin
      w = cfg.grid_width;
    end
    if (cfg.grid_height == '0) begin
      gh = CW'(1);
    end else if (32'(cfg.grid_height) > MAX_SIDE) begin
      gh = CW'(MAX_SIDE);
    end else begin
      gh = cfg.grid_height;
    end
    if (32'(cfg.radius_cells) > MAX_RADIUS) begin
      r = wlcf_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      r = cfg.radius_cells;
    end
  end

  assign ic      = CW'(in_ch.col);
  assign ir      = CW'(in_ch.row);
  assign rr      = CW'(r);
  assign col_hi  = ic + rr;
  assign row_hi  = ir + rr;
  assign in_grid = (ic < w) && (ir < gh);
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept  = in_ch.valid && in_ch.ready;

  assign mem_we    = accept && (in_ch.cmd == wlcf_pkg::CMD_WRITE) && in_grid;
  assign mem_waddr = {SW'(in_ch.row), SW'(in_ch.col)};
  assign mem_wdata = ELEV_BITS'(in_ch.height);
  assign mem_re    = (state_r == S_CTR) || (state_r == S_SCAN);
  assign mem_raddr = (state_r == S_CTR) ? {SW'(row_r), SW'(col_r)}
                                        : {SW'(ri_r), SW'(ci_r)};

  assign div_start = (state_r == S_DIVGO);
  assign div_num   = lower_r;
  assign div_den   = total_r;

  assign load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    c0_nxt    = c0_r;
    c1_nxt    = c1_r;
    r1_nxt    = r1_r;
    ci_nxt    = ci_r;
    ri_nxt    = ri_r;
    lower_nxt = lower_r;
    total_nxt = total_r;
    err_nxt   = err_r;
    if (cmp_pend_r) begin
      total_nxt = total_r + NW'(1);
      if (mem_rdata < center_r) begin
        lower_nxt = lower_r + NW'(1);
      end
    end
    case (state_r)
      S_IDLE: begin
        if (accept && (in_ch.cmd == wlcf_pkg::CMD_QUERY)) begin
          lower_nxt = '0;
          total_nxt = '0;
          col_nxt   = ic;
          row_nxt   = ir;
          ci_nxt    = (ic >= rr) ? ic - rr : '0;
          c0_nxt    = (ic >= rr) ? ic - rr : '0;
          ri_nxt    = (ir >= rr) ? ir - rr : '0;
          c1_nxt    = (col_hi < w) ? col_hi : w - CW'(1);
          r1_nxt    = (row_hi < gh) ? row_hi : gh - CW'(1);
          err_nxt   = !in_grid;
          state_nxt = in_grid ? S_CTR : S_FIN;
        end
      end
      S_CTR: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (ci_r == c1_r) begin
          ci_nxt = c0_r;
          ri_nxt = ri_r + CW'(1);
          if (ri_r == r1_r) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          ci_nxt = ci_r + CW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctr_pend_r  <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_pend_r  <= (state_r == S_CTR);
      cmp_pend_r  <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    c0_r    <= c0_nxt;
    c1_r    <= c1_nxt;
    r1_r    <= r1_nxt;
    ci_r    <= ci_nxt;
    ri_r    <= ri_nxt;
    lower_r <= lower_nxt;
    total_r <= total_nxt;
    err_r   <= err_nxt;
    if (ctr_pend_r) begin
      center_r <= mem_rdata;
    end
    if (load) begin
      out_err_r   <= err_r;
      out_lower_r <= err_r ? '0 : lower_r;
      out_total_r <= err_r ? '0 : total_r;
      out_frac_r  <= err_r ? '0 : div_quot;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.lower_count    = out_lower_r;
  assign out_ch.window_count   = out_total_r;
  assign out_ch.lower_fraction = out_frac_r;
  assign out_ch.query_error    = out_err_r;

endmodule

@@ hw/rtl/window_lower_cell_fraction.sv @@
`timescale 1ns / 1ps
// A write transfer inside the grid stores its height at the accepting edge; one outside the grid is dropped.
// A query reads its clamped window of N cells one cell per cycle through the single store
// read port, followed by a 16-step serial division.
// A query outside the grid skips the scan and division and goes through S_FIN to the output register with an error.
// Synchronous active-low reset sets the registers to a 256 by 256 grid and radius 5;
// the elevation store is not cleared and must be written before it is read.

module window_lower_cell_fraction #(
  parameter int MAX_SIDE   = wlcf_pkg::MAX_SIDE_DEF,
  parameter int MAX_RADIUS = wlcf_pkg::MAX_RADIUS_DEF,
  parameter int ELEV_BITS  = wlcf_pkg::ELEV_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wlcf_in_if.sink                     in_ch,
  wlcf_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wlcf_pkg::APB_AW-1:0] paddr,
  input  logic [wlcf_pkg::APB_DW-1:0] pwdata,
  output logic [wlcf_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int SW = $clog2(MAX_SIDE);

  wlcf_pkg::cfg_t              cfg;
  logic                        mem_we, mem_re;
  logic [2*SW-1:0]             mem_waddr, mem_raddr;
  logic [ELEV_BITS-1:0]        mem_wdata, mem_rdata;
  logic                        div_start, div_done;
  logic [wlcf_pkg::CNT_W-1:0]  div_num, div_den;
  logic [wlcf_pkg::FRAC_W-1:0] div_quot;

  wlcf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wlcf_store #(
    .ADDR_W    (2 * SW),
    .ELEV_BITS (ELEV_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wlcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  wlcf_scan #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_RADIUS (MAX_RADIUS),
    .ELEV_BITS  (ELEV_BITS),
    .SW         (SW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .div_start (div_start),
    .div_done  (div_done),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_quot  (div_quot)
  );

endmodule
